@@ rtl/core/gvf_pkg.sv @@
package gvf_pkg;

	// opcodes
	localparam logic [1:0] OP_LOAD     = 2'd0;
	localparam logic [1:0] OP_CAST     = 2'd1;
	localparam logic [1:0] OP_RD_ENTRY = 2'd2;
	localparam logic [1:0] OP_RD_VIS   = 2'd3;

	// view directions that rotate; all others leave cells as they are
	localparam logic [2:0] DIR_SOUTH = 3'd1;
	localparam logic [2:0] DIR_EAST  = 3'd2;
	localparam logic [2:0] DIR_WEST  = 3'd3;

	// tile codes that block sight
	localparam logic [7:0] TILE_WALL_A = 8'd1;
	localparam logic [7:0] TILE_WALL_B = 8'd4;

	localparam logic [10:0] COUNT_MAX = 11'd2047;

	typedef struct packed {
		logic [1:0] opcode;
		logic [4:0] tile_x;
		logic [4:0] tile_y;
		logic [7:0] tile_code;
		logic [2:0] view_direction;
		logic       clear_visible;
		logic [5:0] bucket_distance;
		logic [4:0] bucket_slot;
	} req_word_t;

	typedef struct packed {
		logic        entry_valid;
		logic [4:0]  entry_x;
		logic [4:0]  entry_y;
		logic        visible_bit;
		logic [10:0] newly_visible_count;
		logic        bucket_overflow;
	} rsp_word_t;

endpackage

@@ rtl/core/gvf_req_if.sv @@
interface gvf_req_if;
	import gvf_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/gvf_rsp_if.sv @@
interface gvf_rsp_if;
	import gvf_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/grid_visibility_flood_cast_core.sv @@
// Load word: idle, then response state; bucket/visibility reads go via read-wait.
// Cast: optional visibility clear, a seed step, then per pop a cell check (off-map
//   stops there), a mark (seen or blocking stops there) and pushes, then respond.
// Memories: registered read port, separate write port; one word at a time.
// Reset: asynchronous, active low; then a clearing pass over all MAP_SIZE*MAP_SIZE
//   cells zeroes the blocking and visibility maps while no word is accepted.
module grid_visibility_flood_cast_core #(
	parameter int MAP_SIZE    = 32,
	parameter int STACK_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	gvf_req_if.sink   req,
	gvf_rsp_if.source rsp
);
	import gvf_pkg::*;

	localparam int XW  = $clog2(MAP_SIZE);
	localparam int CW  = ((XW > 5) ? XW : 5) + 2;    // signed cell coordinate
	localparam int AW  = $clog2(MAP_SIZE * MAP_SIZE);
	localparam int NB  = 2 * MAP_SIZE;
	localparam int BW  = $clog2(NB);
	localparam int BAW = $clog2(NB * MAP_SIZE);
	localparam int FW  = $clog2(MAP_SIZE + 1);
	localparam int SW  = $clog2(STACK_DEPTH);
	localparam int PW  = $clog2(STACK_DEPTH + 1);
	localparam int DW  = CW + 2;                      // |dx|+|dy|

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} cell_t;

	typedef enum logic [3:0] {
		S_RST_CLR, S_IDLE, S_CLR, S_INIT, S_POP, S_CELL, S_MARK, S_PUSH, S_RDWAIT, S_RES
	} state_t;

	function automatic cell_t rotate(input logic [2:0] dir, input cell_t c);
		cell_t r;
		r = c;
		case (dir)
			DIR_SOUTH: begin
				r.x = CW'(MAP_SIZE - 1) - c.x;
				r.y = CW'(MAP_SIZE - 1) - c.y;
			end
			DIR_EAST: begin
				r.x = CW'(MAP_SIZE - 1) - c.y;
				r.y = CW'(MAP_SIZE - 1) - c.x;
			end
			DIR_WEST: begin
				r.x = c.y;
				r.y = c.x;
			end
			default: r = c;
		endcase
		return r;
	endfunction

	// memories
	logic          blk_mem [MAP_SIZE*MAP_SIZE];
	logic          vis_mem [MAP_SIZE*MAP_SIZE];
	logic [2*XW-1:0] bkt_mem [NB*MAP_SIZE];
	logic [FW-1:0] fill_mem [NB];
	cell_t         stk_mem [STACK_DEPTH];

	logic          blk_rd_q, vis_rd_q;
	logic [2*XW-1:0] bkt_rd_q;
	logic [FW-1:0] fill_rd_q;
	cell_t         stk_rd_q;

	logic [AW-1:0]  map_raddr, map_waddr;
	logic           blk_we, blk_wd, vis_we, vis_wd;
	logic [BAW-1:0] bkt_raddr, bkt_waddr;
	logic           bkt_we;
	logic [2*XW-1:0] bkt_wd;
	logic [BW-1:0]  fill_raddr, fill_waddr;
	logic           fill_we;
	logic [FW-1:0]  fill_wd;
	logic [SW-1:0]  stk_raddr, stk_waddr;
	logic           stk_we;
	cell_t          stk_wd;

	// control state
	state_t         state_q;
	logic [AW-1:0]  clr_q;
	logic [PW-1:0]  sp_q;
	logic [NB-1:0]  fvld_q;       // bucket fill count valid, else reads as zero
	logic [2:0]     dir_q;
	cell_t          org_q, cur_q, tr_q;
	logic [AW-1:0]  idx_q;
	logic [BW-1:0]  dist_q;
	logic           dok_q;
	logic [2:0]     mask_q;       // pending pushes: left, right, north
	logic [10:0]    cnt_q;
	logic           ovf_q;
	logic [1:0]     op_q;
	logic           rok_q;
	logic [FW-1:0]  slot_q;
	logic [BW-1:0]  bd_q;
	rsp_word_t      pend_q, rsp_q;
	logic           rsp_vld_q;

	// start cell from the request
	cell_t start_c, cur_rot;
	logic  cur_on;
	logic signed [CW:0] dx, dy;
	logic [DW-1:0] adx, ady, dist_sum;
	logic [FW-1:0] fill_cur;
	logic          req_acc;
	logic          in_map_req;
	rsp_word_t     rd_word;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	always_comb begin
		start_c.x = CW'($unsigned(req.data.tile_x));
		start_c.y = CW'($unsigned(req.data.tile_y));
	end

	assign in_map_req = (32'(req.data.tile_x) < MAP_SIZE) && (32'(req.data.tile_y) < MAP_SIZE);

	// cell checks on the word popped from the stack
	assign cur_rot = rotate(dir_q, stk_rd_q);
	assign cur_on  = (cur_rot.x >= 0) && (cur_rot.x < CW'(MAP_SIZE))
	              && (cur_rot.y >= 0) && (cur_rot.y < CW'(MAP_SIZE));
	assign dx   = (CW+1)'(stk_rd_q.x) - (CW+1)'(org_q.x);
	assign dy   = (CW+1)'(stk_rd_q.y) - (CW+1)'(org_q.y);
	assign adx  = DW'(dx < 0 ? -dx : dx);
	assign ady  = DW'(dy < 0 ? -dy : dy);
	assign dist_sum = adx + ady;

	assign fill_cur = fvld_q[dist_q] ? fill_rd_q : '0;

	// response word for the finished item
	always_comb begin
		rd_word = '0;
		case (op_q)
			OP_CAST: begin
				rd_word.newly_visible_count = cnt_q;
				rd_word.bucket_overflow     = ovf_q;
			end
			OP_RD_ENTRY: begin
				if (rok_q && (slot_q < (fvld_q[bd_q] ? fill_rd_q : FW'(0)))) begin
					rd_word.entry_valid = 1'b1;
					rd_word.entry_x     = 5'(bkt_rd_q[2*XW-1:XW]);
					rd_word.entry_y     = 5'(bkt_rd_q[XW-1:0]);
				end
			end
			OP_RD_VIS: rd_word.visible_bit = rok_q && vis_rd_q;
			default: ;
		endcase
	end

	// memory port selection
	always_comb begin
		map_raddr  = AW'(AW'(cur_rot.y) * AW'(MAP_SIZE) + AW'(cur_rot.x));
		map_waddr  = clr_q;
		blk_we     = 1'b0;
		blk_wd     = 1'b0;
		vis_we     = 1'b0;
		vis_wd     = 1'b0;
		bkt_raddr  = BAW'(BAW'(req.data.bucket_distance) * BAW'(MAP_SIZE)
		           + BAW'(req.data.bucket_slot));
		bkt_waddr  = BAW'(BAW'(dist_q) * BAW'(MAP_SIZE) + BAW'(fill_cur));
		bkt_we     = 1'b0;
		bkt_wd     = {tr_q.x[XW-1:0], tr_q.y[XW-1:0]};
		fill_raddr = BW'(dist_sum);
		fill_waddr = dist_q;
		fill_we    = 1'b0;
		fill_wd    = fill_cur + FW'(1);
		stk_raddr  = SW'(sp_q - PW'(1));
		stk_waddr  = SW'(sp_q);
		stk_we     = 1'b0;
		stk_wd     = org_q;
		case (state_q)
			S_RST_CLR: begin
				blk_we = 1'b1;
				vis_we = 1'b1;
			end
			S_CLR: vis_we = 1'b1;
			S_IDLE: begin
				map_raddr  = AW'(AW'(req.data.tile_y) * AW'(MAP_SIZE) + AW'(req.data.tile_x));
				map_waddr  = map_raddr;
				blk_we     = req_acc && (req.data.opcode == OP_LOAD) && in_map_req;
				blk_wd     = (req.data.tile_code == TILE_WALL_A)
				          || (req.data.tile_code == TILE_WALL_B);
				fill_raddr = BW'(req.data.bucket_distance);
			end
			S_INIT: begin
				stk_we    = 1'b1;
				stk_waddr = '0;
			end
			S_MARK: begin
				map_waddr = idx_q;
				vis_we    = !vis_rd_q;
				vis_wd    = 1'b1;
				bkt_we    = !vis_rd_q && dok_q && (fill_cur < FW'(MAP_SIZE));
				fill_we   = bkt_we;
			end
			S_PUSH: begin
				stk_we = (mask_q != 3'b000) && (sp_q < PW'(STACK_DEPTH));
				stk_wd = cur_q;
				if (mask_q[0]) begin
					stk_wd.x = cur_q.x - CW'(1);
				end else if (mask_q[1]) begin
					stk_wd.x = cur_q.x + CW'(1);
				end else begin
					stk_wd.y = cur_q.y - CW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (blk_we) blk_mem[map_waddr] <= blk_wd;
		if (vis_we) vis_mem[map_waddr] <= vis_wd;
		if (bkt_we) bkt_mem[bkt_waddr] <= bkt_wd;
		if (fill_we) fill_mem[fill_waddr] <= fill_wd;
		if (stk_we) stk_mem[stk_waddr] <= stk_wd;
		blk_rd_q  <= blk_mem[map_raddr];
		vis_rd_q  <= vis_mem[map_raddr];
		bkt_rd_q  <= bkt_mem[bkt_raddr];
		fill_rd_q <= fill_mem[fill_raddr];
		stk_rd_q  <= stk_mem[stk_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			dir_q  <= req.data.view_direction;
			org_q  <= rotate(req.data.view_direction, start_c);
			op_q   <= req.data.opcode;
			bd_q   <= BW'(req.data.bucket_distance);
			slot_q <= FW'(req.data.bucket_slot);
			if (req.data.opcode == OP_RD_ENTRY) begin
				rok_q <= (32'(req.data.bucket_distance) < NB)
				      && (32'(req.data.bucket_slot) < MAP_SIZE);
			end else begin
				rok_q <= in_map_req;
			end
		end
		if (state_q == S_CELL) begin
			cur_q  <= stk_rd_q;
			tr_q   <= cur_rot;
			idx_q  <= map_raddr;
			dist_q <= BW'(dist_sum);
			dok_q  <= 32'(dist_sum) < NB;
			mask_q <= {dy <= 0,
			           (dx <= $signed((CW+1)'(ady))) && (dx >= 0),
			           (dx >= -$signed((CW+1)'(ady))) && (dx <= 0)};
		end
		if (state_q == S_PUSH) begin
			if (mask_q[0]) mask_q[0] <= 1'b0;
			else if (mask_q[1]) mask_q[1] <= 1'b0;
			else mask_q[2] <= 1'b0;
		end
		if (state_q == S_RES && (!rsp_vld_q || rsp.ready)) begin
			rsp_q <= pend_q;
		end
		if (state_q == S_IDLE) begin
			pend_q <= '0;
		end else if (state_q == S_RDWAIT || (state_q == S_POP && sp_q == '0)) begin
			pend_q <= rd_word;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_RST_CLR;
			clr_q     <= '0;
			sp_q      <= '0;
			fvld_q    <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (state_q == S_RES && (!rsp_vld_q || rsp.ready)) rsp_vld_q <= 1'b1;
			else if (rsp.ready) rsp_vld_q <= 1'b0;
			case (state_q)
				S_RST_CLR, S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_SIZE * MAP_SIZE - 1)) begin
						clr_q   <= '0;
						state_q <= (state_q == S_CLR) ? S_INIT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						case (req.data.opcode)
							OP_LOAD: state_q <= S_RES;
							OP_CAST: begin
								fvld_q  <= '0;
								cnt_q   <= '0;
								ovf_q   <= 1'b0;
								state_q <= req.data.clear_visible ? S_CLR : S_INIT;
							end
							default: state_q <= S_RDWAIT;
						endcase
					end
				end
				S_INIT: begin
					sp_q    <= PW'(1);
					state_q <= S_POP;
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_RES;
					end else begin
						sp_q    <= sp_q - PW'(1);
						state_q <= S_CELL;
					end
				end
				S_CELL: state_q <= cur_on ? S_MARK : S_POP;
				S_MARK: begin
					if (vis_rd_q) begin
						state_q <= S_POP;
					end else begin
						if (cnt_q != COUNT_MAX) cnt_q <= cnt_q + 11'd1;
						if (dok_q) begin
							if (fill_cur < FW'(MAP_SIZE)) fvld_q[dist_q] <= 1'b1;
							else ovf_q <= 1'b1;
						end
						state_q <= blk_rd_q ? S_POP : S_PUSH;
					end
				end
				S_PUSH: begin
					if (mask_q == 3'b000) begin
						state_q <= S_POP;
					end else if (sp_q < PW'(STACK_DEPTH)) begin
						sp_q <= sp_q + PW'(1);
					end
				end
				S_RDWAIT: state_q <= S_RES;
				S_RES: begin
					if (!rsp_vld_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/gvf_checker.sv @@
module gvf_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input gvf_pkg::rsp_word_t rsp_data
);
	import gvf_pkg::*;

	// stalled response word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response word changed while stalled");

	// an empty bucket slot reads as zero coordinates
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.entry_valid |-> rsp_data.entry_x == 5'd0
		&& rsp_data.entry_y == 5'd0)
		else $error("empty entry with coordinates");

	// cast results exclude read results
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.newly_visible_count != 11'd0
		|-> !rsp_data.entry_valid && !rsp_data.visible_bit)
		else $error("cast response mixed with read fields");

	// overflow needs at least one marked cell
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.bucket_overflow |-> rsp_data.newly_visible_count != 11'd0)
		else $error("overflow without marked cells");

endmodule

bind grid_visibility_flood_cast_core gvf_checker u_gvf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

@@ test/grid_visibility_flood_cast_checker.sv @@
module grid_visibility_flood_cast_checker
	import gvf_pkg::*;
#(
	parameter int MAP_SIZE    = 32,
	parameter int STACK_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	gvf_req_if   req,
	gvf_rsp_if   rsp,
	output int   pending,
	output int   errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBKT = 2 * MAP_SIZE;

	bit        wall_map [MAP_SIZE*MAP_SIZE];
	bit        seen_map [MAP_SIZE*MAP_SIZE];
	int        bkt_fill [NBKT];
	bit [4:0]  bkt_x    [NBKT][MAP_SIZE];
	bit [4:0]  bkt_y    [NBKT][MAP_SIZE];
	int        lifo_x   [STACK_DEPTH];
	int        lifo_y   [STACK_DEPTH];
	int        lifo_top;
	rsp_word_t expected_rsp_q[$];

	initial begin
		errors = 0;
		foreach (wall_map[i]) begin
			wall_map[i] = 0;
			seen_map[i] = 0;
		end
		foreach (bkt_fill[i]) bkt_fill[i] = 0;
		lifo_top = 0;
	end

	assign pending = expected_rsp_q.size();

	function automatic void turn(input logic [2:0] d, input int x, input int y,
			output int rx, output int ry);
		rx = x;
		ry = y;
		if (d == DIR_SOUTH) begin
			rx = MAP_SIZE - 1 - x;
			ry = MAP_SIZE - 1 - y;
		end else if (d == DIR_EAST) begin
			rx = MAP_SIZE - 1 - y;
			ry = MAP_SIZE - 1 - x;
		end else if (d == DIR_WEST) begin
			rx = y;
			ry = x;
		end
	endfunction

	function automatic void lifo_push(input int x, input int y);
		if (lifo_top < STACK_DEPTH) begin
			lifo_x[lifo_top] = x;
			lifo_y[lifo_top] = y;
			lifo_top++;
		end
	endfunction

	function automatic int iabs(input int v);
		return v < 0 ? -v : v;
	endfunction

	// flood walk; returns count and overflow in the response word
	function automatic rsp_word_t flood(input req_word_t w);
		rsp_word_t r;
		int ox, oy, cx, cy, tx, ty, dx, dy, mdist, idx, cnt;
		r = '0;
		cnt = 0;
		turn(w.view_direction, w.tile_x, w.tile_y, ox, oy);
		if (w.clear_visible)
			foreach (seen_map[i]) seen_map[i] = 0;
		foreach (bkt_fill[i]) bkt_fill[i] = 0;
		lifo_top = 0;
		lifo_push(ox, oy);
		while (lifo_top > 0) begin
			lifo_top--;
			cx = lifo_x[lifo_top];
			cy = lifo_y[lifo_top];
			turn(w.view_direction, cx, cy, tx, ty);
			if (tx < 0 || tx >= MAP_SIZE || ty < 0 || ty >= MAP_SIZE) continue;
			idx = ty * MAP_SIZE + tx;
			if (seen_map[idx]) continue;
			seen_map[idx] = 1;
			if (cnt < COUNT_MAX) cnt++;
			dy = cy - oy;
			dx = cx - ox;
			mdist = iabs(dx) + iabs(dy);
			if (mdist < NBKT) begin
				if (bkt_fill[mdist] < MAP_SIZE) begin
					bkt_x[mdist][bkt_fill[mdist]] = tx[4:0];
					bkt_y[mdist][bkt_fill[mdist]] = ty[4:0];
					bkt_fill[mdist]++;
				end else
					r.bucket_overflow = 1'b1;
			end
			if (wall_map[idx]) continue;
			if (dx >= -iabs(dy) && dx <= 0) lifo_push(cx - 1, cy);
			if (dx <= iabs(dy) && dx >= 0) lifo_push(cx + 1, cy);
			if (dy <= 0) lifo_push(cx, cy - 1);
		end
		r.newly_visible_count = cnt[10:0];
		return r;
	endfunction

	function automatic rsp_word_t predict_rsp(input req_word_t w);
		rsp_word_t r;
		r = '0;
		case (w.opcode)
			OP_LOAD: begin
				if (w.tile_x < MAP_SIZE && w.tile_y < MAP_SIZE)
					wall_map[w.tile_y * MAP_SIZE + w.tile_x] =
						(w.tile_code == TILE_WALL_A || w.tile_code == TILE_WALL_B);
			end
			OP_CAST: r = flood(w);
			OP_RD_ENTRY: begin
				if (w.bucket_distance < NBKT && w.bucket_slot < bkt_fill[w.bucket_distance]) begin
					r.entry_valid = 1'b1;
					r.entry_x = bkt_x[w.bucket_distance][w.bucket_slot];
					r.entry_y = bkt_y[w.bucket_distance][w.bucket_slot];
				end
			end
			default: begin
				if (w.tile_x < MAP_SIZE && w.tile_y < MAP_SIZE)
					r.visible_bit = seen_map[w.tile_y * MAP_SIZE + w.tile_x];
			end
		endcase
		return r;
	endfunction

	task automatic report(input string field, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		rsp_word_t want, got;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: response word with nothing expected", $realtime);
					errors++;
				end else begin
					want = expected_rsp_q.pop_front();
					if (got.entry_valid != want.entry_valid)
						report("entry_valid", got.entry_valid, want.entry_valid);
					if (got.entry_x != want.entry_x) report("entry_x", got.entry_x, want.entry_x);
					if (got.entry_y != want.entry_y) report("entry_y", got.entry_y, want.entry_y);
					if (got.visible_bit != want.visible_bit)
						report("visible_bit", got.visible_bit, want.visible_bit);
					if (got.newly_visible_count != want.newly_visible_count)
						report("newly_visible_count", got.newly_visible_count,
							want.newly_visible_count);
					if (got.bucket_overflow != want.bucket_overflow)
						report("bucket_overflow", got.bucket_overflow, want.bucket_overflow);
				end
			end
			if (req.valid && req.ready)
				expected_rsp_q.push_back(predict_rsp(req.data));
		end
	end

endmodule

@@ test/grid_visibility_flood_cast_core_tb.sv @@
module grid_visibility_flood_cast_core_tb;
	import gvf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   pending;
	int   errors;
	int   n_words;
	int   n_casts;
	int   n_reads;
	int   burst_left;

	gvf_req_if req_ch();
	gvf_rsp_if rsp_ch();

	grid_visibility_flood_cast_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	grid_visibility_flood_cast_checker i_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.pending(pending),
		.errors (errors)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Response side: mixes free-running stretches with stretches of random stalls,
	// picking the mode anew at random at the end of each stretch.
	int  stall_phase;
	bit  stall_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_phase  <= 0;
			stall_mode   <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				stall_phase <= $urandom_range(20, 80);
				stall_mode  <= $urandom_range(0, 2) != 0;
			end else
				stall_phase <= stall_phase - 1;
			rsp_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	function automatic req_word_t mk(input logic [1:0] op, input int x, input int y,
			input int code = 0, input int dir = 0, input bit clr = 0,
			input int bd = 0, input int bs = 0);
		req_word_t w;
		w.opcode          = op;
		w.tile_x          = x[4:0];
		w.tile_y          = y[4:0];
		w.tile_code       = code[7:0];
		w.view_direction  = dir[2:0];
		w.clear_visible   = clr;
		w.bucket_distance = bd[5:0];
		w.bucket_slot     = bs[4:0];
		return w;
	endfunction

	// Drives one word and holds it until accepted; valid stays high into the next
	// word unless a burst ends and a random gap follows.
	task automatic send_word(input req_word_t w);
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		n_words++;
		if (w.opcode == OP_CAST) n_casts++;
		if (w.opcode == OP_RD_ENTRY || w.opcode == OP_RD_VIS) n_reads++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				req_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end else
			burst_left--;
	endtask

	// random load: walls get a fair share so flood shapes vary
	function automatic req_word_t rand_load();
		int code;
		case ($urandom_range(0, 3))
			0: code = TILE_WALL_A;
			1: code = TILE_WALL_B;
			default: code = $urandom_range(0, 255);
		endcase
		return mk(OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 31), code);
	endfunction

	function automatic req_word_t rand_word();
		req_word_t w;
		w = req_word_t'({$urandom, $urandom});
		return w;
	endfunction

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		req_word_t w;
		int k;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		n_words    = 0;
		n_casts    = 0;
		n_reads    = 0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: cast on the empty map, reads of extremes, wall codes, all eight
		// direction codes including the five that do not rotate, reads of the top bucket and slot.
		send_word(mk(OP_RD_VIS, 31, 31));
		send_word(mk(OP_RD_ENTRY, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_CAST, 16, 16, 0, 0, 1));
		send_word(mk(OP_RD_ENTRY, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_RD_ENTRY, 0, 0, 0, 0, 0, 63, 31));
		send_word(mk(OP_RD_ENTRY, 0, 0, 0, 0, 0, 10, 31));
		send_word(mk(OP_RD_VIS, 16, 0));
		send_word(mk(OP_LOAD, 16, 15, TILE_WALL_A));
		send_word(mk(OP_LOAD, 17, 16, TILE_WALL_B));
		send_word(mk(OP_LOAD, 31, 31, 255));
		send_word(mk(OP_LOAD, 0, 0, 0));
		for (k = 0; k < 8; k++)
			send_word(mk(OP_CAST, (k * 9) % 32, 31 - k * 4, 0, k, k != 3));
		send_word(mk(OP_CAST, 0, 0, 0, 1, 1));
		send_word(mk(OP_CAST, 31, 0, 255, 2, 0, 63, 31));
		send_word(mk(OP_RD_ENTRY, 0, 0, 0, 0, 0, 1, 0));
		send_word(mk(OP_RD_VIS, 0, 31));

		// Pause until everything is back before the random part.
		drain();

		// Random: mostly well-formed scenes (loads, cast, targeted reads), plus noise.
		while (n_words < 290) begin
			if ($urandom_range(0, 5) == 0) begin
				send_word(rand_word());
			end else begin
				repeat ($urandom_range(0, 10)) send_word(rand_load());
				send_word(mk(OP_CAST, $urandom_range(0, 31), $urandom_range(0, 31), 0,
					$urandom_range(0, 7), $urandom_range(0, 3) != 0));
				repeat ($urandom_range(2, 8)) begin
					if ($urandom_range(0, 1))
						send_word(mk(OP_RD_ENTRY, 0, 0, 0, 0, 0,
							$urandom_range(0, 15), $urandom_range(0, 4)));
					else
						send_word(mk(OP_RD_VIS, $urandom_range(0, 31), $urandom_range(0, 31)));
				end
			end
			if ($urandom_range(0, 15) == 0) drain();
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d words: %0d casts, %0d reads, the rest loads and random noise.",
			n_words, n_casts, n_reads);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#50ms;
		$display("Timeout with %0d responses outstanding", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
